@@ hdl/vdf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_pkg
// Shared widths, stage indexes and types of the velocity drag force block.
// ----------------------------------------------------------------------------
package vdf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VEL_W     = 32;
  localparam int COEF_W    = 31;
  localparam int SQ_W      = 2 * VEL_W;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int KP_W      = COEF_W + ROOT_W;
  localparam int C_W       = KP_W - FRAC_BITS + 1;
  localparam int CHI_W     = C_W - VEL_W;
  localparam int PROD_W    = VEL_W + C_W;
  localparam int A_W       = PROD_W - FRAC_BITS;

  // pipeline stage indexes
  localparam int ST_SUM   = 2;
  localparam int ST_ROOT  = ST_SUM + ROOT_W;
  localparam int ST_KP    = ST_ROOT + 1;
  localparam int ST_C     = ST_KP + 1;
  localparam int ST_OUT   = ST_C + 3;
  localparam int DEPTH    = ST_OUT + 1;

  localparam logic REG_LINEAR = 1'b0;
  localparam logic REG_SQUARE = 1'b1;

  typedef struct packed {
    logic signed [VEL_W-1:0] drag;
    logic                    clip;
  } drag_res_t;

endpackage
`default_nettype wire

@@ hdl/vdf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_if
// Valid/ready channels for velocity beats in and drag beats out.
// ----------------------------------------------------------------------------
interface vdf_vel_if import vdf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  modport source (output valid, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, output ready);
endinterface

interface vdf_drag_if import vdf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] drag_x;
  logic signed [VEL_W-1:0] drag_y;
  logic signed [VEL_W-1:0] drag_z;
  logic                    clipped;
  modport source (output valid, drag_x, drag_y, drag_z, clipped, input ready);
  modport sink   (input valid, drag_x, drag_y, drag_z, clipped, output ready);
endinterface
`default_nettype wire

@@ hdl/vdf_lane_sq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_lane_sq
// One component lane: magnitude and sign, then the square of the magnitude.
// ----------------------------------------------------------------------------
module vdf_lane_sq import vdf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    adv,
  input  wire logic signed [VEL_W-1:0] vel,
  output logic        [VEL_W-1:0]      mag,
  output logic                         neg,
  output logic        [SQ_W-1:0]       sq
);

  always_ff @(posedge clk) begin
    if (adv) begin
      neg <= vel[VEL_W-1];
      // most negative value maps to 2^31, still fits unsigned
      mag <= vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
      sq  <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

endmodule
`default_nettype wire

@@ hdl/vdf_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vdf_sqrt import vdf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire logic [SQ_W-1:0]   rad,
  output logic      [ROOT_W-1:0] root
);

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   n_q    [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   n_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = rad;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign n_in    = n_q[j-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], n_in[SQ_W-1:SQ_W-2]};
    assign trial  = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (adv) begin
        n_q[j] <= {n_in[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[j]  <= rem_sh - trial;
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh;
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule
`default_nettype wire

@@ hdl/vdf_lane_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_lane_out
// One component lane: |v|*c split in two products, recombine, scale,
// negate and saturate. The last stage is the output register.
// ----------------------------------------------------------------------------
module vdf_lane_out import vdf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [VEL_W-1:0] mag,
  input  wire logic             neg,
  input  wire logic [C_W-1:0]   coef,
  output drag_res_t             res
);

  logic [2*VEL_W-1:0]       p_lo;
  logic [VEL_W+CHI_W-1:0]   p_hi;
  logic                     neg_a;
  logic [PROD_W-1:0]        prod;
  logic                     neg_b;
  logic [A_W-1:0]           a_full;
  logic [A_W-1:0]           limit;
  logic [A_W-1:0]           a_sat;
  logic                     sat;

  assign a_full = prod[PROD_W-1:FRAC_BITS];
  // drag is positive when v is negative
  assign limit  = neg_b ? A_W'(33'h07FFF_FFFF) : A_W'(33'h080000000);
  assign sat    = a_full > limit;
  assign a_sat  = sat ? limit : a_full;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo  <= (2*VEL_W)'(mag) * (2*VEL_W)'(coef[VEL_W-1:0]);
      p_hi  <= (VEL_W+CHI_W)'(mag) * (VEL_W+CHI_W)'(coef[C_W-1:VEL_W]);
      neg_a <= neg;
      prod  <= {p_hi, {VEL_W{1'b0}}} + PROD_W'(p_lo);
      neg_b <= neg_a;
      res.clip <= sat;
      res.drag <= neg_b ? a_sat[VEL_W-1:0] : VEL_W'(-a_sat[VEL_W-1:0]);
    end
  end

endmodule
`default_nettype wire

@@ hdl/velocity_drag_force.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_drag_force
// Linear plus quadratic drag: -v*(k1 + k2*|v|), saturated per component.
// Throughput: one beat per cycle while the output is not stalled; the 32-stage
// square root pipeline and the split 32x48 component products each take a new
// operand every cycle. The whole pipeline holds while the output register
// waits on a stall. Reset clears both coefficients and all stage valid bits.
// ----------------------------------------------------------------------------
module velocity_drag_force import vdf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [COEF_W-1:0] cfg_data,
  vdf_vel_if.sink                vel,
  vdf_drag_if.source             drag
);

  logic [COEF_W-1:0] k1;
  logic [COEF_W-1:0] k2;
  logic              adv;
  logic [DEPTH-1:0]  vld;

  logic [VEL_W-1:0]  mag [3];
  logic              neg [3];
  logic [SQ_W-1:0]   sq  [3];
  logic [SQ_W-1:0]   ssum;
  logic [ROOT_W-1:0] root;
  logic [KP_W-1:0]   kp;
  logic [C_W-1:0]    coef;
  drag_res_t         res [3];

  // magnitude/sign delay line, entry i is stage i+1
  logic [VEL_W:0]    dly [3][ST_C];

  assign adv       = !drag.valid || drag.ready;
  assign vel.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= '0;
      k2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINEAR: k1 <= cfg_data;
        REG_SQUARE: k2 <= cfg_data;
        default:    k1 <= k1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], vel.valid};
    end
  end

  vdf_lane_sq u_sq_x (.clk, .adv, .vel(vel.vel_x), .mag(mag[0]), .neg(neg[0]), .sq(sq[0]));
  vdf_lane_sq u_sq_y (.clk, .adv, .vel(vel.vel_y), .mag(mag[1]), .neg(neg[1]), .sq(sq[1]));
  vdf_lane_sq u_sq_z (.clk, .adv, .vel(vel.vel_z), .mag(mag[2]), .neg(neg[2]), .sq(sq[2]));

  for (genvar l = 0; l < 3; l++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dly[l][0] <= {neg[l], mag[l]};
        for (int i = 1; i < ST_C; i++) begin
          dly[l][i] <= dly[l][i-1];
        end
      end
    end
  end

  // sum of squares is at most 3*2^62
  always_ff @(posedge clk) begin
    if (adv) begin
      ssum <= sq[0] + sq[1] + sq[2];
      kp   <= KP_W'(k2) * KP_W'(root);
      coef <= C_W'(k1) + C_W'(kp[KP_W-1:FRAC_BITS]);
    end
  end

  vdf_sqrt u_sqrt (.clk, .adv, .rad(ssum), .root(root));

  for (genvar l = 0; l < 3; l++) begin : g_out
    vdf_lane_out u_out (
      .clk,
      .adv,
      .mag  (dly[l][ST_C-1][VEL_W-1:0]),
      .neg  (dly[l][ST_C-1][VEL_W]),
      .coef (coef),
      .res  (res[l])
    );
  end

  assign drag.valid   = vld[ST_OUT];
  assign drag.drag_x  = res[0].drag;
  assign drag.drag_y  = res[1].drag;
  assign drag.drag_z  = res[2].drag;
  assign drag.clipped = res[0].clip | res[1].clip | res[2].clip;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !drag.valid)
    else $error("output valid right after reset");

  a_clip_extreme: assert property (@(posedge clk) disable iff (rst)
    drag.valid && drag.clipped |->
      drag.drag_x == 32'sh7FFFFFFF || drag.drag_x == 32'sh80000000 ||
      drag.drag_y == 32'sh7FFFFFFF || drag.drag_y == 32'sh80000000 ||
      drag.drag_z == 32'sh7FFFFFFF || drag.drag_z == 32'sh80000000)
    else $error("clip flagged without a saturated component");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !vel.ready |-> drag.valid && !drag.ready)
    else $error("input held off without an output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> vld == $past(vld))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

@@ bench/velocity_drag_force_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_drag_force_tb
// Self-checking bench for the drag force block. Velocity beats are driven
// through the valid/ready channel, and each beat is run through a bit-exact
// drag predictor. Drag beats are compared field by field, in order, while both
// sides idle and stall at random. The coefficients change only after a drain.
// ----------------------------------------------------------------------------
module velocity_drag_force_tb;
  import vdf_pkg::*;

  typedef struct {
    logic signed [VEL_W-1:0] dx;
    logic signed [VEL_W-1:0] dy;
    logic signed [VEL_W-1:0] dz;
    logic                    clip;
  } drag_exp_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [COEF_W-1:0] cfg_data;

  vdf_vel_if  vel_ch ();
  vdf_drag_if drag_ch ();

  velocity_drag_force u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vel       (vel_ch),
    .drag      (drag_ch)
  );

  drag_exp_t         drag_pending[$];
  logic [COEF_W-1:0] k_lin;
  logic [COEF_W-1:0] k_sq;
  int                errors;
  int                send_idle;
  int                recv_stall;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5ms;
    $display("[velocity_drag_force] ERROR");
    $finish;
  end

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [64:0] rem;
    logic [64:0] root;
    logic [64:0] b;
    rem  = 65'(n);
    root = '0;
    b    = 65'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[63:0];
  endfunction

  function automatic drag_exp_t drag_predict(logic signed [VEL_W-1:0] vx,
                                             logic signed [VEL_W-1:0] vy,
                                             logic signed [VEL_W-1:0] vz);
    logic [VEL_W-1:0] v[3];
    logic [VEL_W-1:0] mag[3];
    logic             neg[3];
    logic [31:0]      res[3];
    logic [63:0]      s;
    logic [63:0]      m;
    logic [95:0]      c;
    logic [95:0]      a;
    logic [95:0]      lim;
    drag_exp_t        e;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    e.clip = 1'b0;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i][VEL_W-1];
      mag[i] = neg[i] ? -v[i] : v[i];
      s = s + 64'(mag[i]) * 64'(mag[i]);
    end
    m = root_floor(s);
    c = 96'(k_lin) + ((96'(k_sq) * 96'(m)) >> FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      a   = (96'(mag[i]) * c) >> FRAC_BITS;
      lim = neg[i] ? 96'h7FFF_FFFF : 96'h8000_0000;
      if (a > lim) begin
        a = lim;
        e.clip = 1'b1;
      end
      res[i] = neg[i] ? a[31:0] : -a[31:0];
    end
    e.dx = res[0];
    e.dy = res[1];
    e.dz = res[2];
    return e;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    drag_ch.ready = ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    drag_exp_t e;
    if (!rst && drag_ch.valid && drag_ch.ready) begin
      if (drag_pending.size() == 0) begin
        $display("%0t: drag beat with nothing expected: %h %h %h %b", $time,
                 drag_ch.drag_x, drag_ch.drag_y, drag_ch.drag_z, drag_ch.clipped);
        errors++;
      end else begin
        e = drag_pending.pop_front();
        if (drag_ch.drag_x !== e.dx || drag_ch.drag_y !== e.dy ||
            drag_ch.drag_z !== e.dz || drag_ch.clipped !== e.clip) begin
          $display("%0t: mismatch exp %h %h %h %b got %h %h %h %b", $time,
                   e.dx, e.dy, e.dz, e.clip, drag_ch.drag_x, drag_ch.drag_y,
                   drag_ch.drag_z, drag_ch.clipped);
          errors++;
        end
      end
    end
  end

  task automatic write_coeff(logic idx, logic [COEF_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_LINEAR) k_lin = val;
    else k_sq = val;
  endtask

  task automatic set_coeffs(logic [COEF_W-1:0] k1, logic [COEF_W-1:0] k2);
    write_coeff(REG_LINEAR, k1);
    write_coeff(REG_SQUARE, k2);
  endtask

  task automatic send_vel(logic signed [VEL_W-1:0] vx, logic signed [VEL_W-1:0] vy,
                          logic signed [VEL_W-1:0] vz);
    while ($urandom_range(99) < send_idle) begin
      vel_ch.valid = 1'b0;
      @(negedge clk);
    end
    vel_ch.valid = 1'b1;
    vel_ch.vel_x = vx;
    vel_ch.vel_y = vy;
    vel_ch.vel_z = vz;
    do @(posedge clk); while (!vel_ch.ready);
    drag_pending = {drag_pending, drag_predict(vx, vy, vz)};
    @(negedge clk);
  endtask

  // beats in flight drain, then the pipeline gets time to go quiet
  task automatic drain();
    vel_ch.valid = 1'b0;
    while (drag_pending.size() != 0) @(negedge clk);
    repeat (DEPTH + 10) @(negedge clk);
  endtask

  function automatic logic signed [VEL_W-1:0] rand_vel();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(1 << 21)) - (1 << 20);
      2: return $signed($urandom_range(1 << 25)) - (1 << 24);
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(1 << 17)) - (1 << 16);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [VEL_W-1:0] ext[6];
    ext = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1_0000, -32'sh1_0000, -32'sh1};
    set_coeffs(31'h0001_0000, 31'h0000_8000);
    send_vel(0, 0, 0);
    for (int i = 0; i < 6; i++) send_vel(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
    send_vel(32'sh0001_0000, 0, 0);
    drain();
    set_coeffs(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_vel(0, 0, 0);
    send_vel(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
    send_vel(1, -1, 0);
    send_vel(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    drain();
    set_coeffs('0, '0);
    send_vel(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
    drain();
    set_coeffs('0, 31'h7FFF_FFFF);
    send_vel(1, 1, 1);
    send_vel(32'sh100, -32'sh100, 0);
    send_vel(32'sh8000_0000, 0, 0);
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, int n);
    send_idle  = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        drain();
        case ($urandom_range(3))
          0: set_coeffs(COEF_W'($urandom_range(1 << 20)), COEF_W'($urandom_range(1 << 18)));
          1: set_coeffs(COEF_W'($urandom), COEF_W'($urandom));
          2: set_coeffs(COEF_W'($urandom_range(1 << 16)), '0);
          default: set_coeffs('0, COEF_W'($urandom_range(1 << 12)));
        endcase
      end
      send_vel(rand_vel(), rand_vel(), rand_vel());
    end
    drain();
  endtask

  initial begin
    errors       = 0;
    k_lin        = '0;
    k_sq         = '0;
    send_idle    = 0;
    recv_stall   = 0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_LINEAR;
    cfg_data     = '0;
    vel_ch.valid = 1'b0;
    vel_ch.vel_x = '0;
    vel_ch.vel_y = '0;
    vel_ch.vel_z = '0;
    drag_ch.ready = 1'b1;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    // coefficients read zero out of reset
    send_vel(32'sh7FFF_FFFF, -32'sh5, 32'sh10_0000);
    drain();
    test_directed();
    test_random_phase(0, 0, 450);
    test_random_phase(49, 0, 450);
    test_random_phase(0, 49, 450);
    test_random_phase(28, 28, 450);
    if (errors == 0) begin
      $display("[velocity_drag_force] OK");
    end else begin
      $display("[velocity_drag_force] ERROR");
    end
    $finish;
  end

endmodule

@@ velocity_drag_force.f @@
hdl/vdf_pkg.sv
hdl/vdf_if.sv
hdl/vdf_lane_sq.sv
hdl/vdf_sqrt.sv
hdl/vdf_lane_out.sv
hdl/velocity_drag_force.sv
bench/velocity_drag_force_tb.sv
